>>> design/lu_pkg.sv
// shared types and constants of the linear upsampler
package lu_pkg;

    localparam int LU_SLOTS    = 8;   // longest run that one source sample can cause
    localparam int LU_CNT_W    = 4;   // holds 0 .. LU_SLOTS
    localparam int LU_SMP_W    = 16;  // sample bit pattern width
    localparam int LU_CFG_IDX_W = 2;
    localparam int LU_CFG_DAT_W = 2;

    // configuration register indexes
    localparam logic [LU_CFG_IDX_W-1:0] CFG_RATE_SHIFT  = 2'd0;
    localparam logic [LU_CFG_IDX_W-1:0] CFG_SOURCE_WIDE = 2'd1;
    localparam logic [LU_CFG_IDX_W-1:0] CFG_DEST_WIDE   = 2'd2;

    // rate codes
    localparam logic [1:0] RATE_1X = 2'd0;

    typedef struct packed {
        logic [1:0] rate_shift;
        logic       source_wide;
        logic       dest_wide;
    } t_cfg;

    typedef struct packed {
        logic [LU_SLOTS-1:0][LU_SMP_W-1:0] vals;  // slot 0 goes out first
        logic [LU_CNT_W-1:0]               n;
        logic                              fin;
    } t_run;

endpackage

>>> design/lu_interp.sv
// combinational interpolation of one source sample into a run of output samples
module lu_interp import lu_pkg::*; (
    input  t_cfg                i_cfg,
    input  logic [LU_SMP_W-1:0] i_sample,
    input  logic                i_fin,
    input  logic [LU_SMP_W-1:0] i_held_sample,
    input  logic                i_held_valid,
    output t_run                o_run,
    output logic [LU_SMP_W-1:0] o_n_held_sample,
    output logic                o_n_held_valid
);

    // floor((a+b)/2) in 17-bit signed domain
    function automatic logic signed [16:0] half_sum(logic signed [16:0] a,
                                                    logic signed [16:0] b);
        logic signed [17:0] s;
        s = {a[16], a} + {b[16], b};
        return s[17:1];
    endfunction

    function automatic logic [LU_SMP_W-1:0] to_pat(logic signed [16:0] v, logic wide);
        return wide ? v[15:0] : {8'h00, v[7:0]};
    endfunction

    logic                wide;
    logic [7:0]          byte_in;
    logic signed [16:0]  cur;
    logic signed [16:0]  prev;
    logic signed [16:0]  mid;
    logic signed [16:0]  q1;
    logic signed [16:0]  q3;
    logic                is4;
    logic [LU_CNT_W-1:0] fac;
    logic [LU_SMP_W-1:0] cur_pat;

    assign wide    = i_cfg.source_wide | i_cfg.dest_wide;
    assign byte_in = i_sample[7:0];

    always_comb begin
        if (i_cfg.source_wide) begin
            cur = {i_sample[15], i_sample};
        end else if (wide) begin
            // (b - 0x80) << 8
            cur = {~byte_in[7], ~byte_in[7], byte_in[6:0], 8'h00};
        end else begin
            cur = {9'b0, byte_in};
        end
    end

    // held pattern read in the format that is current now
    assign prev = wide ? {i_held_sample[15], i_held_sample} : {9'b0, i_held_sample[7:0]};
    assign mid  = half_sum(prev, cur);
    assign q1   = half_sum(prev, mid);
    assign q3   = half_sum(mid, cur);

    assign is4     = i_cfg.rate_shift[1];  // undefined code 3 saturates to 4x
    assign fac     = is4 ? LU_CNT_W'(4) : LU_CNT_W'(2);
    assign cur_pat = to_pat(cur, wide);

    always_comb begin
        o_run.fin = i_fin;
        for (int k = 0; k < LU_SLOTS; k++) begin
            o_run.vals[k] = cur_pat;
        end
        o_n_held_sample = i_held_sample;
        o_n_held_valid  = 1'b0;
        if (i_cfg.rate_shift == RATE_1X) begin
            o_run.n = LU_CNT_W'(1);
        end else begin
            o_run.n = (i_held_valid ? fac : '0) + (i_fin ? fac : '0);
            if (i_held_valid) begin
                o_run.vals[0] = to_pat(prev, wide);
                o_run.vals[1] = is4 ? to_pat(q1, wide) : to_pat(mid, wide);
                if (is4) begin
                    o_run.vals[2] = to_pat(mid, wide);
                    o_run.vals[3] = to_pat(q3, wide);
                end
            end
            if (i_fin) begin
                o_n_held_sample = '0;
            end else begin
                o_n_held_sample = cur_pat;
                o_n_held_valid  = 1'b1;
            end
        end
    end

endmodule

>>> design/lu_run_buf.sv
// result shift line for one run of output samples, one beat per ready cycle
module lu_run_buf import lu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_run                i_run,
    output logic                o_free,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [LU_SMP_W-1:0] m_axis_tdata,   // [15:0] out_sample
    output logic                m_axis_tlast,   // run_end
    output logic                m_axis_tuser    // [0] stream_end
);

    logic [LU_SLOTS-1:0][LU_SMP_W-1:0] r_vals;
    logic [LU_CNT_W-1:0]               r_cnt;
    logic                              r_fin;
    logic                              beat;

    assign beat   = m_axis_tvalid & m_axis_tready;
    assign o_free = (r_cnt == '0) || ((r_cnt == LU_CNT_W'(1)) && m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_run.n;
        end else if (beat) begin
            r_cnt <= r_cnt - LU_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vals <= i_run.vals;
            r_fin  <= i_run.fin;
        end else if (beat) begin
            for (int i = 0; i < LU_SLOTS - 1; i++) begin
                r_vals[i] <= r_vals[i+1];
            end
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_vals[0];
    assign m_axis_tlast  = (r_cnt == LU_CNT_W'(1));
    assign m_axis_tuser  = r_fin & (r_cnt == LU_CNT_W'(1));

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LU_CNT_W'(LU_SLOTS))
        else $error("run count beyond slot count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (o_free && i_run.n != '0))
        else $error("run loaded while busy or empty");

    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == $past(i_run.n)))
        else $error("run count not taken from load");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && !i_load) |=> (r_cnt == $past(r_cnt) - LU_CNT_W'(1)))
        else $error("count did not drop on beat");

endmodule

>>> design/linear_upsampler_unit.sv
// top level of the linear interpolation audio upsampler (1x, 2x, 4x)
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+--------------------------------
//  cfg      | in        | i_cfg_valid / o_cfg_ready   | i_cfg_addr register, i_cfg_data
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata sample_value, tlast final
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata out_sample, tlast run_end,
//           |           |                             | tuser stream_end
//
// a source sample gives 0 to 8 output beats from the result shift line, one per cycle
// while m_axis_tready is high; a steady run holds 1 beat at 1x, 2 at 2x, 4 at 4x
// the input register takes the next sample while the current run is still draining
// reset (synchronous, active low) empties both stages and clears the held sample
// stalls on m_axis hold the run in place and back up into s_axis after one sample

module linear_upsampler_unit import lu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [LU_CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [LU_CFG_DAT_W-1:0] i_cfg_data,
    // source samples
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [LU_SMP_W-1:0]     s_axis_tdata,   // [15:0] sample_value
    input  logic                    s_axis_tlast,   // final_sample
    // output samples
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [LU_SMP_W-1:0]     m_axis_tdata,   // [15:0] out_sample
    output logic                    m_axis_tlast,   // run_end
    output logic                    m_axis_tuser    // [0] stream_end
);

    // configuration registers
    t_cfg r_cfg;

    // input register
    logic                r_in_valid;
    logic [LU_SMP_W-1:0] r_in_sample;
    logic                r_in_fin;

    // previous sample, kept in output format
    logic [LU_SMP_W-1:0] r_held_sample;
    logic                r_held_valid;

    t_run                run;
    logic [LU_SMP_W-1:0] n_held_sample;
    logic                n_held_valid;
    logic                run_free;
    logic                consume;
    logic                load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_RATE_SHIFT:  r_cfg.rate_shift  <= i_cfg_data[1:0];
                CFG_SOURCE_WIDE: r_cfg.source_wide <= i_cfg_data[0];
                CFG_DEST_WIDE:   r_cfg.dest_wide   <= i_cfg_data[0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    lu_interp u_interp (
        .i_cfg           (r_cfg),
        .i_sample        (r_in_sample),
        .i_fin           (r_in_fin),
        .i_held_sample   (r_held_sample),
        .i_held_valid    (r_held_valid),
        .o_run           (run),
        .o_n_held_sample (n_held_sample),
        .o_n_held_valid  (n_held_valid)
    );

    // a sample that yields no beats retires at once; others wait for a free shift line
    assign consume       = r_in_valid && ((run.n == '0) || run_free);
    assign load          = consume && (run.n != '0);
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata;
            r_in_fin    <= s_axis_tlast;
        end
    end

    // held state moves on when the sample in the input register retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_sample <= '0;
            r_held_valid  <= 1'b0;
        end else if (consume) begin
            r_held_sample <= n_held_sample;
            r_held_valid  <= n_held_valid;
        end
    end

    lu_run_buf u_run_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_run         (run),
        .o_free        (run_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_fin) |=> !r_held_valid)
        else $error("held sample still valid after final sample");

    a_1x_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_cfg.rate_shift == RATE_1X) |-> (run.n == LU_CNT_W'(1)))
        else $error("1x run is not a single beat");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !consume) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("input register lost a waiting sample");

endmodule
